[rtl/lse_pkg.sv]
`timescale 1ns / 1ps

package lse_pkg;

	// Number of carrying pixels that hold the byte count at the head of a frame.
	localparam int HEADER_BITS = 32;
	// Bits needed for the carried-bit position, which runs up to HEADER_BITS + 7.
	localparam int CB_W = 6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_INDEX_W-1:0] REG_MODE         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP         = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_MASK     = 3'd5;

	localparam logic MODE_EMBED   = 1'b0;
	localparam logic MODE_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_PIXEL = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} chan_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EMPTY   = 3'd1,
		ST_NO_TEXT = 3'd2,
		ST_FULL    = 3'd3,
		ST_DONE    = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] message_byte;
		logic       frame_start;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} item_t;

	typedef struct packed {
		logic       pixel_valid;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       byte_valid;
		logic [7:0] recovered_byte;
		logic       byte_last;
		logic [2:0] status;
	} result_t;

endpackage

[rtl/lse_if.sv]
`timescale 1ns / 1ps

// Input item channel.
interface lse_item_if
	import lse_pkg::*;
	();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// Result item channel.
interface lse_result_if
	import lse_pkg::*;
	();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/lsb_stego_embed_extract.sv]
`timescale 1ns / 1ps
// Each input transfer passes through the input register and then the result register.
// One item per clock unless results stall; ready stays high while the result register drains.
// The message store is a one-port-write, one-port-read memory with a registered read.
// Reset (arst_n low, asynchronous) clears all control state and sets the configuration
// registers to their defaults; the message store contents are not cleared.

module lsb_stego_embed_extract
	import lse_pkg::*;
#(
	parameter int STORE_DEPTH = 4096,
	parameter int MAX_WIDTH   = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	lse_item_if.sink               items,
	lse_result_if.source           results,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

	// Store address, stored-count, column and effective-width widths.
	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int SCW = $clog2(STORE_DEPTH + 1);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int EW  = $clog2(MAX_WIDTH + 1);

	// Configuration registers.
	logic        mode_q;
	logic [1:0]  channel_q;
	logic [7:0]  step_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [7:0]  key_q;
	logic [25:0] area_q;

	// Frame and message state.
	logic [SCW-1:0]  stored_q;
	logic [CW-1:0]   col_q;
	logic [7:0]      phase_q;
	logic [CB_W-1:0] cb_q;
	logic [31:0]     hdr_q;
	logic [7:0]      gather_q;
	logic [23:0]     emitted_q;
	logic            bad_q;

	// Next-state values, meaningful when the item in the input register moves on.
	logic [SCW-1:0]  stored_n;
	logic [CW-1:0]   col_n;
	logic [7:0]      phase_n;
	logic [CB_W-1:0] cb_n;
	logic [31:0]     hdr_n;
	logic [7:0]      gather_n;
	logic [23:0]     emitted_n;
	logic            bad_n;

	// Pipeline registers.
	item_t   item_s1;
	logic    item_v_s1;
	result_t result_s2;
	logic    result_v_s2;
	logic    adv;

	// Message store and its read side.
	logic [7:0]    store_mem [STORE_DEPTH];
	logic [7:0]    rdata_q;
	logic [7:0]    wdata_q;
	logic          hit_q;
	logic          wr_req;
	logic          store_we;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic [7:0]    store_byte;

	// Working signals of the pixel path.
	logic [31:0]     effw_w;
	logic [EW-1:0]   effw;
	logic [CW-1:0]   col_c;
	logic [7:0]      phase_c;
	logic [CB_W-1:0] cb_c;
	logic [31:0]     hdr_c;
	logic [7:0]      gather_c;
	logic [23:0]     emitted_c;
	logic            bad_c;
	logic [7:0]      px [3];
	logic [1:0]      sel;
	logic            carry;
	logic            tx_bit;
	logic [7:0]      tx_byte;
	logic [2:0]      pos;
	logic [31:0]     sc_ext;
	logic [7:0]      gath_w;
	logic [EW:0]     col_inc;
	logic [8:0]      phase_inc;
	result_t         result_c;

	// The input register moves on whenever the result register is empty or being drained,
	// so the block keeps taking one transfer per clock under a free-running consumer.
	assign adv         = item_v_s1 && (!result_v_s2 || results.ready);
	assign items.ready = !item_v_s1 || adv;

	assign results.valid = result_v_s2;
	assign results.data  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			item_v_s1 <= 1'b1;
		end else if (adv) begin
			item_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1 <= items.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_v_s2 <= 1'b0;
		end else if (adv) begin
			result_v_s2 <= 1'b1;
		end else if (results.ready) begin
			result_v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result_c;
		end
	end

	// Configuration writes. The header plausibility bound (width times height) is kept
	// registered so that the multiply stays out of the pixel path; configuration must only
	// change while idle, which the block does not enforce, so the product is settled in time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_EMBED;
			channel_q <= CH_RED;
			step_q    <= 8'd1;
			width_q   <= 13'd640;
			height_q  <= 13'd480;
			key_q     <= 8'd0;
			area_q    <= 26'd307200;
		end else begin
			area_q <= 26'(width_q) * 26'(height_q);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODE:         mode_q    <= cfg_wr_data[0];
					REG_CHANNEL:      channel_q <= cfg_wr_data[1:0];
					REG_STEP:         step_q    <= cfg_wr_data[7:0];
					REG_IMAGE_WIDTH:  width_q   <= cfg_wr_data;
					REG_IMAGE_HEIGHT: height_q  <= cfg_wr_data;
					REG_KEY_MASK:     key_q     <= cfg_wr_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// Widths above the column counter's reach are clamped for column counting.
	assign effw_w = (32'(width_q) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(width_q);
	assign effw   = effw_w[EW-1:0];

	// The store is read every clock at the byte index that will be current in the next
	// cycle, so a carrying pixel always finds its message byte already registered. A load
	// that writes the very entry being read is forwarded around the memory.
	assign store_we   = wr_req && adv;
	assign wr_addr    = stored_q[AW-1:0];
	assign rd_addr    = adv ? emitted_n[AW-1:0] : emitted_q[AW-1:0];
	assign store_byte = hit_q ? wdata_q : rdata_q;

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[wr_addr] <= item_s1.message_byte;
		end
		rdata_q <= store_mem[rd_addr];
		wdata_q <= item_s1.message_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= store_we && (wr_addr == rd_addr);
		end
	end

	// One item's work: store maintenance for clear and load, bit insertion or recovery
	// for a pixel. A frame start clears the position and message counters before the
	// pixel itself is handled.
	always_comb begin
		stored_n  = stored_q;
		col_n     = col_q;
		phase_n   = phase_q;
		cb_n      = cb_q;
		hdr_n     = hdr_q;
		gather_n  = gather_q;
		emitted_n = emitted_q;
		bad_n     = bad_q;
		wr_req    = 1'b0;
		result_c  = '0;

		col_c     = item_s1.frame_start ? '0 : col_q;
		phase_c   = item_s1.frame_start ? '0 : phase_q;
		cb_c      = item_s1.frame_start ? '0 : cb_q;
		hdr_c     = item_s1.frame_start ? '0 : hdr_q;
		gather_c  = item_s1.frame_start ? '0 : gather_q;
		emitted_c = item_s1.frame_start ? '0 : emitted_q;
		bad_c     = item_s1.frame_start ? 1'b0 : bad_q;

		px[0] = item_s1.in_red;
		px[1] = item_s1.in_green;
		px[2] = item_s1.in_blue;

		// Channel code three is treated as blue.
		case (channel_q)
			CH_RED:   sel = 2'd0;
			CH_GREEN: sel = 2'd1;
			default:  sel = 2'd2;
		endcase

		carry = (col_c != '0) && (EW'(col_c) < effw) && (step_q != 8'd0)
			&& (phase_c == 8'd0);

		tx_bit    = 1'b0;
		tx_byte   = store_byte ^ key_q;
		pos       = cb_c[2:0];
		sc_ext    = 32'(stored_q);
		gath_w    = gather_c;
		col_inc   = (EW + 1)'(col_c) + 1'b1;
		phase_inc = {1'b0, phase_c} + 9'd1;

		case (item_s1.operation)
			OP_CLEAR: begin
				stored_n = '0;
			end
			OP_LOAD: begin
				if (stored_q < SCW'(STORE_DEPTH)) begin
					wr_req   = 1'b1;
					stored_n = stored_q + 1'b1;
				end else begin
					result_c.status = ST_FULL;
				end
			end
			OP_PIXEL: begin
				cb_n      = cb_c;
				hdr_n     = hdr_c;
				gather_n  = gather_c;
				emitted_n = emitted_c;
				bad_n     = bad_c;

				if (mode_q == MODE_EMBED) begin
					if (stored_q == '0) begin
						result_c.status = ST_EMPTY;
					end else if ((cb_c >= CB_W'(HEADER_BITS))
						&& (emitted_c >= 24'(stored_q))) begin
						result_c.status = ST_DONE;
					end else if (carry) begin
						if (cb_c < CB_W'(HEADER_BITS)) begin
							// Byte count, least significant bit first.
							tx_bit = sc_ext[cb_c[4:0]];
							cb_n   = cb_c + 1'b1;
						end else begin
							tx_bit = tx_byte[pos];
							if (pos == 3'd7) begin
								cb_n      = CB_W'(HEADER_BITS);
								emitted_n = emitted_c + 1'b1;
							end else begin
								cb_n = cb_c + 1'b1;
							end
						end
						px[sel][0] = tx_bit;
						if ((cb_n >= CB_W'(HEADER_BITS)) && (emitted_n >= 24'(stored_q))) begin
							result_c.status = ST_DONE;
						end
					end
				end else begin
					if (bad_c) begin
						result_c.status = ST_NO_TEXT;
					end else if (carry) begin
						tx_bit = px[sel][0];
						if (cb_c < CB_W'(HEADER_BITS)) begin
							hdr_n = hdr_c | (32'(tx_bit) << cb_c[4:0]);
							cb_n  = cb_c + 1'b1;
							// Last header bit: the count must be nonzero and below the area.
							if (cb_c == CB_W'(HEADER_BITS - 1)) begin
								if ((hdr_n == 32'd0) || (hdr_n >= 32'(area_q))) begin
									bad_n           = 1'b1;
									result_c.status = ST_NO_TEXT;
								end
							end
						end else if (32'(emitted_c) < hdr_c) begin
							gath_w = gather_c | (8'(tx_bit) << pos);
							if (pos == 3'd7) begin
								result_c.byte_valid     = 1'b1;
								result_c.recovered_byte = gath_w ^ key_q;
								result_c.byte_last      = (32'(emitted_c) + 32'd1) == hdr_c;
								emitted_n               = emitted_c + 1'b1;
								gather_n                = '0;
								cb_n                    = CB_W'(HEADER_BITS);
							end else begin
								gather_n = gath_w;
								cb_n     = cb_c + 1'b1;
							end
						end
					end
				end

				// Column and step phase advance; both wrap at the end of a row.
				if (col_inc >= (EW + 1)'(effw)) begin
					col_n   = '0;
					phase_n = '0;
				end else begin
					col_n   = col_c + 1'b1;
					phase_n = (phase_inc >= {1'b0, step_q}) ? 8'd0 : phase_c + 1'b1;
				end

				result_c.pixel_valid = 1'b1;
				result_c.out_red     = px[0];
				result_c.out_green   = px[1];
				result_c.out_blue    = px[2];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q  <= '0;
			col_q     <= '0;
			phase_q   <= '0;
			cb_q      <= '0;
			hdr_q     <= '0;
			gather_q  <= '0;
			emitted_q <= '0;
			bad_q     <= 1'b0;
		end else if (adv) begin
			stored_q  <= stored_n;
			col_q     <= col_n;
			phase_q   <= phase_n;
			cb_q      <= cb_n;
			hdr_q     <= hdr_n;
			gather_q  <= gather_n;
			emitted_q <= emitted_n;
			bad_q     <= bad_n;
		end
	end

endmodule

[rtl/lse_checker.sv]
`timescale 1ns / 1ps

module lse_checker
	import lse_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    result_valid,
	input logic    result_ready,
	input result_t result_data
);

	// A stalled result holds its value until the transfer.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// The last-byte flag only comes with a recovered byte on a pixel.
	a_last_with_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.byte_last |->
		result_data.byte_valid && result_data.pixel_valid)
		else $error("byte_last without a recovered byte");

	// Store operations return empty pixel and byte fields.
	a_store_op_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.pixel_valid |->
		result_data.out_red == 8'd0 && result_data.out_green == 8'd0
		&& result_data.out_blue == 8'd0 && !result_data.byte_valid)
		else $error("non-pixel result carries data");

	// A recovered byte is only ever reported with status ok.
	a_byte_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.byte_valid |-> result_data.status == ST_OK)
		else $error("recovered byte with a non-ok status");

endmodule

bind lsb_stego_embed_extract lse_checker u_lse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (results.valid),
	.result_ready (results.ready),
	.result_data  (results.data)
);
